@@ rtl/core/sba_pkg.sv @@
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and constants of the superblock block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sba_pkg;

  localparam int unsigned IDX_W    = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned GROUPS_W = 5;
  localparam int unsigned FG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS = 2'd1;

  localparam logic [COUNT_W-1:0]  BLOCKS_RST = 9'd256;
  localparam logic [GROUPS_W-1:0] GROUPS_RST = 5'd8;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [FG_W-1:0] FG_MAX = 4'd15;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic [IDX_W-1:0]   granted_index;
    logic               release_error;
    logic [COUNT_W-1:0] free_total;
    logic [FG_W-1:0]    fullness_group;
    logic               all_free;
    logic               any_free;
  } rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/sba_divider.sv @@
// ----------------------------------------------------------------------------
// sba_divider
// Serial restoring divider, one quotient bit per cycle, for a quotient known
// to fit in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sba_divider #(
  parameter int unsigned NW = 17,
  parameter int unsigned DW = 9,
  parameter int unsigned QW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quot,
  output logic               fin
);

  localparam int unsigned KW = (QW > 1) ? $clog2(QW) : 1;

  logic [NW-1:0] rem;
  logic [KW-1:0] step;
  logic          running;
  logic [NW-1:0] den_sh;
  logic          fits;

  assign den_sh = NW'(den) << step;
  assign fits   = rem >= den_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && step == '0) begin
        running <= 1'b0;
        fin     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem  <= num;
      step <= KW'(QW - 1);
      quot <= '0;
    end else if (running) begin
      if (fits) begin
        rem  <= rem - den_sh;
        quot <= quot | (QW'(1) << step);
      end
      step <= step - KW'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/superblock_block_allocator.sv @@
// ----------------------------------------------------------------------------
// superblock_block_allocator
// Fixed-size block allocator for one superblock: LIFO of released indices,
// bump counter for never-used blocks, free count and fullness group.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Its result shows on
// rsp for exactly one cycle with done high; busy then drops and the next
// command can be taken in the cycle after done. The serial divider that forms
// the fullness group produces one quotient bit per cycle. The receiver cannot
// stall done. The release stack needs no clearing after reset. Configuration
// writes are always taken (cfg_ready is high) and are meant for idle times.
`default_nettype none

module superblock_block_allocator
  import sba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 256,
  parameter int unsigned MAX_GROUPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire req_t                 req,
  output logic                      done,
  output rsp_t                      rsp,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned GW = $clog2(MAX_GROUPS + 1);
  localparam int unsigned QW = $clog2(MAX_GROUPS);
  localparam int unsigned PW = CW + GW;
  localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);
  localparam logic [GW-1:0] MAXG = GW'(MAX_GROUPS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_STAT = 5'b00100,
    S_LOAD = 5'b01000,
    S_DIV  = 5'b10000
  } state_t;

  state_t state;
  logic   out_pending;

  logic [COUNT_W-1:0]  blocks_cfg;
  logic [GROUPS_W-1:0] groups_cfg;
  logic [CW-1:0]       depth;
  logic [CW-1:0]       carved;
  req_t                req_q;

  logic [IDX_W-1:0] stack_mem [MAX_BLOCKS];
  logic [IDX_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;

  logic [CW-1:0] count;
  logic [GW-1:0] groups;
  logic [GW-1:0] gm2;
  logic [CW-1:0] uncarved;
  logic [CW:0]   free_sum;
  logic [CW-1:0] free_cur;
  logic [CW-1:0] used_cur;
  logic          rel_reject;

  logic             granted_q;
  logic [IDX_W-1:0] gidx_q;
  logic             rerr_q;
  logic             from_stack;
  logic [CW-1:0]    free_q;
  logic             all_free_q;
  logic             any_free_q;
  logic [PW-1:0]    prod;

  logic          div_go;
  logic [QW-1:0] div_q;
  logic          div_fin;
  logic [7:0]    fg_sum;
  logic [FG_W-1:0] fg;

  // effective configuration
  always_comb begin
    if (blocks_cfg == '0) begin
      count = CW'(1);
    end else if (32'(blocks_cfg) > MAX_BLOCKS) begin
      count = MAXB;
    end else begin
      count = CW'(blocks_cfg);
    end
    if (groups_cfg < 5'd2) begin
      groups = GW'(2);
    end else if (32'(groups_cfg) > MAX_GROUPS) begin
      groups = MAXG;
    end else begin
      groups = GW'(groups_cfg);
    end
    gm2 = groups - GW'(2);
  end

  // free count from the current state
  always_comb begin
    uncarved = (carved < count) ? count - carved : '0;
    free_sum = {1'b0, uncarved} + {1'b0, depth};
    free_cur = (free_sum > {1'b0, count}) ? count : free_sum[CW-1:0];
    used_cur = count - free_cur;
    rel_reject = (free_cur >= count) || (depth >= MAXB);
  end

  assign busy      = (state != S_IDLE) || out_pending;
  assign cfg_ready = 1'b1;
  assign done      = out_pending;
  assign rd_addr   = AW'(depth - CW'(1));
  assign mem_we    = (state == S_EXEC) && (req_q.func == FUNC_RELEASE) && !rel_reject;
  assign div_go    = (state == S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_cfg <= BLOCKS_RST;
      groups_cfg <= GROUPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLOCKS: blocks_cfg <= cfg_data;
        CFG_GROUPS: groups_cfg <= cfg_data[GROUPS_W-1:0];
        default: ;
      endcase
    end
  end

  // release stack
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[depth[AW-1:0]] <= req_q.block_index;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= stack_mem[rd_addr];
  end

  // sequencer and allocator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_pending <= 1'b0;
      depth       <= '0;
      carved      <= '0;
    end else begin
      out_pending <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (req_q.func == FUNC_ALLOC) begin
            if (depth != '0) begin
              depth <= depth - CW'(1);
            end else if (carved < count) begin
              carved <= carved + CW'(1);
            end
          end else if (!rel_reject) begin
            depth <= depth + CW'(1);
          end
          state <= S_STAT;
        end
        S_STAT: state <= S_LOAD;
        S_LOAD: state <= S_DIV;
        S_DIV: begin
          if (div_fin) begin
            state       <= S_IDLE;
            out_pending <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // per-command payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    case (state)
      S_EXEC: begin
        granted_q  <= 1'b0;
        gidx_q     <= '0;
        rerr_q     <= 1'b0;
        from_stack <= 1'b0;
        if (req_q.func == FUNC_ALLOC) begin
          if (depth != '0) begin
            granted_q  <= 1'b1;
            from_stack <= 1'b1;
          end else if (carved < count) begin
            granted_q <= 1'b1;
            gidx_q    <= 8'(carved);
          end
        end else begin
          rerr_q <= rel_reject;
        end
      end
      S_STAT: begin
        if (from_stack) begin
          gidx_q <= rd_data;
        end
        free_q     <= free_cur;
        all_free_q <= free_cur == count;
        any_free_q <= (depth != '0) || (carved < count);
        prod       <= PW'(used_cur) * PW'(gm2);
      end
      S_DIV: begin
        if (div_fin) begin
          rsp.granted        <= granted_q;
          rsp.granted_index  <= gidx_q;
          rsp.release_error  <= rerr_q;
          rsp.free_total     <= COUNT_W'(free_q);
          rsp.fullness_group <= fg;
          rsp.all_free       <= all_free_q;
          rsp.any_free       <= any_free_q;
        end
      end
      default: ;
    endcase
  end

  sba_divider #(
    .NW (PW),
    .DW (CW),
    .QW (QW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (prod),
    .den  (count),
    .quot (div_q),
    .fin  (div_fin)
  );

  always_comb begin
    fg_sum = 8'(div_q) + 8'd1;
    if (all_free_q) begin
      fg = '0;
    end else if (fg_sum > 8'(FG_MAX)) begin
      fg = FG_MAX;
    end else begin
      fg = fg_sum[FG_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the superblock block allocator. Commands go in one at a time
// over the start/busy handshake, and an in-bench copy of the allocator (release
// stack, carve counter, both registers) predicts each result. Results are
// compared field by field as done strobes. The run covers directed corner
// cases first, then random allocate/release walks under changing register
// settings, some with random idle bursts on the command side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import sba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_SLOTS  = 256;
  localparam int unsigned GROUPS_CAP   = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_TICKS = 20;

  // indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  req_t                 req;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COUNT_W-1:0]   cfg_data;

  // allocator copy
  logic [IDX_W-1:0]    freed_stack [STACK_SLOTS];
  int unsigned         freed_depth = 0;
  int unsigned         carved_blocks = 0;
  logic [COUNT_W-1:0]  blocks_reg = BLOCKS_RST;
  logic [GROUPS_W-1:0] groups_reg = GROUPS_RST;

  rsp_t             pending_answers [$];
  logic [IDX_W-1:0] held_blocks [$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;

  superblock_block_allocator DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned free_blocks(int unsigned cnt);
    int unsigned uncarved;
    uncarved = (carved_blocks < cnt) ? cnt - carved_blocks : 0;
    return (uncarved + freed_depth > cnt) ? cnt : uncarved + freed_depth;
  endfunction

  function automatic rsp_t predict_answer(req_t cmd);
    rsp_t        ans;
    int unsigned cnt;
    int unsigned grp;
    int unsigned free_c;
    int unsigned fg;
    cnt = blocks_reg;
    if (cnt < 1) cnt = 1;
    if (cnt > STACK_SLOTS) cnt = STACK_SLOTS;
    grp = groups_reg;
    if (grp < 2) grp = 2;
    if (grp > GROUPS_CAP) grp = GROUPS_CAP;
    ans = '0;
    if (cmd.func == FUNC_ALLOC) begin
      if (freed_depth > 0) begin
        freed_depth--;
        ans.granted = 1'b1;
        ans.granted_index = freed_stack[freed_depth];
      end else if (carved_blocks < cnt) begin
        ans.granted = 1'b1;
        ans.granted_index = IDX_W'(carved_blocks);
        carved_blocks++;
      end
    end else begin
      if (free_blocks(cnt) >= cnt || freed_depth >= STACK_SLOTS) begin
        ans.release_error = 1'b1;
      end else begin
        freed_stack[freed_depth] = cmd.block_index;
        freed_depth++;
      end
    end
    free_c = free_blocks(cnt);
    if (free_c == cnt) begin
      fg = 0;
    end else begin
      fg = 1 + ((cnt - free_c) * (grp - 2)) / cnt;
      if (fg > FG_MAX) fg = FG_MAX;
    end
    ans.free_total = COUNT_W'(free_c);
    ans.fullness_group = FG_W'(fg);
    ans.all_free = (free_c == cnt);
    ans.any_free = (freed_depth > 0) || (carved_blocks < cnt);
    return ans;
  endfunction

  function automatic req_t make_cmd(logic f, logic [IDX_W-1:0] idx);
    req_t c;
    c.func = f;
    c.block_index = idx;
    return c;
  endfunction

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
    end
  endtask

  // entered and left at a falling edge
  task automatic issue_cmd(input req_t cmd, input int unsigned gap);
    rsp_t ans;
    if (gap != 0) begin
      start = 1'b0;
      while (busy) @(negedge clk);
      repeat (gap) @(negedge clk);
    end
    req = cmd;
    start = 1'b1;
    do @(posedge clk); while (busy);
    ans = predict_answer(cmd);
    pending_answers.push_back(ans);
    if (ans.granted) held_blocks.push_back(ans.granted_index);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending_answers.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COUNT_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_BLOCKS) blocks_reg = data;
    else if (idx == CFG_GROUPS) groups_reg = data[GROUPS_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  task automatic set_random_config();
    logic [COUNT_W-1:0]  blocks;
    logic [GROUPS_W-1:0] groups;
    int unsigned         which;
    case ($urandom_range(0, 5))
      0: blocks = 9'd1;
      1: blocks = 9'd256;
      2: blocks = 9'($urandom_range(2, 16));
      3: blocks = 9'($urandom_range(17, 255));
      4: blocks = 9'($urandom_range(257, 511));
      default: blocks = 9'd0;
    endcase
    case ($urandom_range(0, 4))
      0: groups = 5'd2;
      1: groups = 5'd16;
      2: groups = 5'($urandom_range(3, 15));
      3: groups = 5'($urandom_range(0, 1));
      default: groups = 5'($urandom_range(17, 31));
    endcase
    which = $urandom_range(0, 3);
    wait_idle();
    if (which != 1) write_reg(CFG_BLOCKS, blocks);
    if (which != 2) write_reg(CFG_GROUPS, {4'($urandom_range(0, 15)), groups});
  endtask

  // random walk; releases mostly return blocks that are held
  task automatic run_walk(input int unsigned n, input int unsigned alloc_pct,
                          input bit idle_on);
    int unsigned      gap;
    int unsigned      k;
    logic [IDX_W-1:0] idx;
    for (int unsigned i = 0; i < n; i++) begin
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if ($urandom_range(0, 99) < alloc_pct) begin
        issue_cmd(make_cmd(FUNC_ALLOC, 8'($urandom_range(0, 255))), gap);
      end else begin
        if (held_blocks.size() != 0 && $urandom_range(0, 3) != 0) begin
          k = $urandom_range(0, held_blocks.size() - 1);
          idx = held_blocks[k];
          held_blocks.delete(k);
        end else begin
          idx = 8'($urandom_range(0, 255));
        end
        issue_cmd(make_cmd(FUNC_RELEASE, idx), gap);
      end
      if (idle_on && $urandom_range(0, 199) == 0) wait_idle();
    end
  endtask

  task automatic test_reset_state();
    issue_cmd(make_cmd(FUNC_RELEASE, 8'h5A), 0);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'hFF), 0);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'h00), 2);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'hA5), 0);
    issue_cmd(make_cmd(FUNC_RELEASE, 8'hFF), 0);
    issue_cmd(make_cmd(FUNC_RELEASE, 8'h00), 1);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'h00), 0);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'h00), 0);
  endtask

  task automatic test_config_edges();
    // one block, fewer than already carved; groups from masked data
    wait_idle();
    write_reg(CFG_BLOCKS, 9'd1);
    write_reg(CFG_GROUPS, 9'h1E0);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'h00), 0);
    issue_cmd(make_cmd(FUNC_RELEASE, 8'hFF), 0);
    issue_cmd(make_cmd(FUNC_RELEASE, 8'h00), 0);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'h00), 0);
    // zero count and one group, plus writes to unused indexes
    wait_idle();
    write_reg(CFG_BLOCKS, 9'd0);
    write_reg(CFG_GROUPS, 9'd1);
    write_reg(CFG_SPARE_A, 9'($urandom_range(0, 511)));
    write_reg(CFG_SPARE_B, 9'($urandom_range(0, 511)));
    issue_cmd(make_cmd(FUNC_RELEASE, 8'h80), 0);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'h7F), 0);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'h00), 0);
    // counts and groups above the maximum
    wait_idle();
    write_reg(CFG_BLOCKS, 9'h1FF);
    write_reg(CFG_GROUPS, 9'h01F);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'h00), 0);
    issue_cmd(make_cmd(FUNC_RELEASE, 8'h01), 0);
    wait_idle();
    write_reg(CFG_GROUPS, 9'd16);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'h00), 0);
    issue_cmd(make_cmd(FUNC_ALLOC, 8'h00), 3);
  endtask

  task automatic test_random_traffic();
    int unsigned pct;
    // carve through a full superblock first
    wait_idle();
    write_reg(CFG_BLOCKS, 9'd256);
    write_reg(CFG_GROUPS, 9'd16);
    run_walk(280, 95, 1'b1);
    for (int unsigned p = 0; p < 9; p++) begin
      set_random_config();
      case ($urandom_range(0, 2))
        0: pct = 15;
        1: pct = 50;
        default: pct = 85;
      endcase
      run_walk($urandom_range(50, 90), pct, $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic test_unpaced_tail();
    set_random_config();
    run_walk(80, 50, 1'b0);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        check_field("done with nothing pending", 1, 0);
      end else begin
        want = pending_answers.pop_front();
        check_field("granted", rsp.granted, want.granted);
        check_field("granted_index", rsp.granted_index, want.granted_index);
        check_field("release_error", rsp.release_error, want.release_error);
        check_field("free_total", rsp.free_total, want.free_total);
        check_field("fullness_group", rsp.fullness_group, want.fullness_group);
        check_field("all_free", rsp.all_free, want.all_free);
        check_field("any_free", rsp.any_free, want.any_free);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_config_edges();
    test_random_traffic();
    test_unpaced_tail();
    wait_idle();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ superblock_block_allocator.f @@
rtl/core/sba_pkg.sv
rtl/core/sba_divider.sv
rtl/core/superblock_block_allocator.sv
dv/tb.sv
